[rtl/single_wire_humidity_sensor_reader_macros.svh]
// Assertion macros used by the sensor reader top level.
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_MACROS_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SWHS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swhs check failed");

// Next-cycle implication, disabled during reset.
`define SWHS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swhs check failed");

`endif

[rtl/swhs_pkg.sv]
// Shared types and constants of the single-wire sensor reader.
`default_nettype none

package swhs_pkg;

  // Width of the tick counter; timing registers are used in their low bits.
  localparam int COUNT_WIDTH = 16;
  localparam int REG_WIDTH   = 16;
  localparam int FRAME_WIDTH = 4;
  localparam int IDX_WIDTH   = 3;
  localparam int DATA_WIDTH  = 16;
  localparam int MAX_FRAME   = 8;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  // Register indexes of the configuration port.
  typedef enum logic [IDX_WIDTH-1:0] {
    REG_START_LOW   = 3'd0,
    REG_RELEASE     = 3'd1,
    REG_RESP_SAMPLE = 3'd2,
    REG_RESP_CONF   = 3'd3,
    REG_BIT_SAMPLE  = 3'd4,
    REG_FRAME_BYTES = 3'd5,
    REG_WAIT_TMO    = 3'd6
  } reg_idx_t;

  // Input beat kinds.
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_t;

  // End status codes.
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_RESPONSE = 2'd1,
    ST_BAD_RESP    = 2'd2,
    ST_TIMEOUT     = 2'd3
  } status_t;

  // Exchange phases.
  typedef enum logic [3:0] {
    PH_IDLE         = 4'd0,
    PH_START_LOW    = 4'd1,
    PH_START_HIGH   = 4'd2,
    PH_RESP_SAMPLE  = 4'd3,
    PH_RESP_CONFIRM = 4'd4,
    PH_RESP_FALL    = 4'd5,
    PH_BIT_RISE     = 4'd6,
    PH_BIT_DELAY    = 4'd7,
    PH_BIT_FALL     = 4'd8
  } phase_t;

  // Configuration register contents.
  typedef struct packed {
    logic [REG_WIDTH-1:0]   start_low_ticks;
    logic [REG_WIDTH-1:0]   release_ticks;
    logic [REG_WIDTH-1:0]   response_sample_ticks;
    logic [REG_WIDTH-1:0]   response_confirm_ticks;
    logic [REG_WIDTH-1:0]   bit_sample_ticks;
    logic [FRAME_WIDTH-1:0] frame_bytes;
    logic [REG_WIDTH-1:0]   wait_timeout_ticks;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic       busy_res;
    logic       status_valid;
    status_t    status;
    logic       last_byte;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       drive_level;
    logic       drive_enable;
  } res_t;

endpackage

`default_nettype wire

[rtl/swhs_cfg.sv]
// Configuration register file of the sensor reader.
`default_nettype none

module swhs_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [swhs_pkg::IDX_WIDTH-1:0]   cfg_index,
  input  wire logic [swhs_pkg::REG_WIDTH-1:0]   cfg_data,
  output swhs_pkg::cfg_t                        cfg
);

  logic wr;

  // Always take a write; unknown indexes drop.
  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid;

  // Hold registers, load the addressed one.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_low_ticks        <= 16'd18000;
      cfg.release_ticks          <= 16'd40;
      cfg.response_sample_ticks  <= 16'd50;
      cfg.response_confirm_ticks <= 16'd70;
      cfg.bit_sample_ticks       <= 16'd50;
      cfg.frame_bytes            <= 4'd5;
      cfg.wait_timeout_ticks     <= 16'd200;
    end else if (wr) begin
      case (cfg_index)
        swhs_pkg::REG_START_LOW:   cfg.start_low_ticks        <= cfg_data;
        swhs_pkg::REG_RELEASE:     cfg.release_ticks          <= cfg_data;
        swhs_pkg::REG_RESP_SAMPLE: cfg.response_sample_ticks  <= cfg_data;
        swhs_pkg::REG_RESP_CONF:   cfg.response_confirm_ticks <= cfg_data;
        swhs_pkg::REG_BIT_SAMPLE:  cfg.bit_sample_ticks       <= cfg_data;
        swhs_pkg::REG_FRAME_BYTES:
          cfg.frame_bytes <= cfg_data[swhs_pkg::FRAME_WIDTH-1:0];
        swhs_pkg::REG_WAIT_TMO:    cfg.wait_timeout_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/swhs_core.sv]
// Exchange state machine: one step per accepted beat.
`default_nettype none

module swhs_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire logic           op,
  input  wire logic           pin_level,
  input  swhs_pkg::cfg_t      cfg,
  output swhs_pkg::res_t      res
);

  swhs_pkg::phase_t phase, phase_next;
  swhs_pkg::cnt_t   tick_count, tick_count_next;
  logic [2:0]       bit_index, bit_index_next;
  logic [7:0]       shift_byte, shift_byte_next;
  logic [2:0]       byte_count, byte_count_next;

  swhs_pkg::cnt_t   timed_lim;
  swhs_pkg::cnt_t   wait_lim;
  logic             timed_done;
  logic             wait_expired;
  logic             want;
  logic [swhs_pkg::FRAME_WIDTH-1:0] frame;
  logic [swhs_pkg::FRAME_WIDTH-1:0] bytes_done;
  logic [2:0]       bit_inc;

  // Pick the limit of the current timed phase.
  always_comb begin
    case (phase)
      swhs_pkg::PH_START_LOW:    timed_lim = swhs_pkg::cnt_t'(cfg.start_low_ticks);
      swhs_pkg::PH_START_HIGH:   timed_lim = swhs_pkg::cnt_t'(cfg.release_ticks);
      swhs_pkg::PH_RESP_SAMPLE:  timed_lim = swhs_pkg::cnt_t'(cfg.response_sample_ticks);
      swhs_pkg::PH_RESP_CONFIRM: timed_lim = swhs_pkg::cnt_t'(cfg.response_confirm_ticks);
      default:                   timed_lim = swhs_pkg::cnt_t'(cfg.bit_sample_ticks);
    endcase
  end

  // Timeout of zero acts as one.
  assign wait_lim = (swhs_pkg::cnt_t'(cfg.wait_timeout_ticks) == '0) ?
                    swhs_pkg::cnt_t'(1) : swhs_pkg::cnt_t'(cfg.wait_timeout_ticks);
  assign timed_done   = (tick_count >= timed_lim);
  assign wait_expired = ({1'b0, tick_count} + {{swhs_pkg::COUNT_WIDTH{1'b0}}, 1'b1})
                        >= {1'b0, wait_lim};
  assign want = (phase == swhs_pkg::PH_BIT_RISE);

  // Clamp the frame length to one through eight bytes.
  always_comb begin
    if (cfg.frame_bytes == '0) begin
      frame = swhs_pkg::FRAME_WIDTH'(1);
    end else if (cfg.frame_bytes > swhs_pkg::FRAME_WIDTH'(swhs_pkg::MAX_FRAME)) begin
      frame = swhs_pkg::FRAME_WIDTH'(swhs_pkg::MAX_FRAME);
    end else begin
      frame = cfg.frame_bytes;
    end
  end

  assign bytes_done = {1'b0, byte_count} + swhs_pkg::FRAME_WIDTH'(1);
  assign bit_inc    = bit_index + 3'd1;

  // Next state and result of one step.
  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    byte_count_next = byte_count;
    res             = '0;

    if (op == swhs_pkg::OP_START) begin
      if (phase == swhs_pkg::PH_IDLE) begin
        phase_next      = swhs_pkg::PH_START_LOW;
        tick_count_next = '0;
        bit_index_next  = '0;
        shift_byte_next = '0;
        byte_count_next = '0;
      end
    end else begin
      case (phase)
        swhs_pkg::PH_IDLE: ;
        swhs_pkg::PH_START_LOW, swhs_pkg::PH_START_HIGH,
        swhs_pkg::PH_RESP_SAMPLE, swhs_pkg::PH_RESP_CONFIRM,
        swhs_pkg::PH_BIT_DELAY: begin
          if (!timed_done) begin
            tick_count_next = tick_count + swhs_pkg::cnt_t'(1);
          end else begin
            tick_count_next = '0;
            case (phase)
              swhs_pkg::PH_START_LOW:  phase_next = swhs_pkg::PH_START_HIGH;
              swhs_pkg::PH_START_HIGH: phase_next = swhs_pkg::PH_RESP_SAMPLE;
              swhs_pkg::PH_RESP_SAMPLE: begin
                if (!pin_level) begin
                  phase_next = swhs_pkg::PH_RESP_CONFIRM;
                end else begin
                  phase_next       = swhs_pkg::PH_IDLE;
                  res.status       = swhs_pkg::ST_NO_RESPONSE;
                  res.status_valid = 1'b1;
                end
              end
              swhs_pkg::PH_RESP_CONFIRM: begin
                if (pin_level) begin
                  phase_next = swhs_pkg::PH_RESP_FALL;
                end else begin
                  phase_next       = swhs_pkg::PH_IDLE;
                  res.status       = swhs_pkg::ST_BAD_RESP;
                  res.status_valid = 1'b1;
                end
              end
              default: begin
                // Bit delay: shift in the sampled level.
                shift_byte_next = {shift_byte[6:0], pin_level};
                phase_next      = swhs_pkg::PH_BIT_FALL;
              end
            endcase
          end
        end
        swhs_pkg::PH_RESP_FALL, swhs_pkg::PH_BIT_RISE, swhs_pkg::PH_BIT_FALL: begin
          if (pin_level == want) begin
            tick_count_next = '0;
            if (phase == swhs_pkg::PH_RESP_FALL) begin
              phase_next = swhs_pkg::PH_BIT_RISE;
            end else if (phase == swhs_pkg::PH_BIT_RISE) begin
              phase_next = swhs_pkg::PH_BIT_DELAY;
            end else begin
              bit_index_next = bit_inc;
              if (bit_inc == 3'd0) begin
                res.data_byte  = shift_byte;
                res.byte_valid = 1'b1;
                if (bytes_done >= frame) begin
                  res.last_byte    = 1'b1;
                  res.status_valid = 1'b1;
                  res.status       = swhs_pkg::ST_OK;
                  phase_next       = swhs_pkg::PH_IDLE;
                end else begin
                  byte_count_next = byte_count + 3'd1;
                  shift_byte_next = '0;
                  phase_next      = swhs_pkg::PH_BIT_RISE;
                end
              end else begin
                phase_next = swhs_pkg::PH_BIT_RISE;
              end
            end
          end else if (wait_expired) begin
            phase_next       = swhs_pkg::PH_IDLE;
            tick_count_next  = '0;
            res.status       = swhs_pkg::ST_TIMEOUT;
            res.status_valid = 1'b1;
          end else begin
            tick_count_next = tick_count + swhs_pkg::cnt_t'(1);
          end
        end
        default: phase_next = swhs_pkg::PH_IDLE;
      endcase
    end

    res.drive_enable = (phase_next == swhs_pkg::PH_START_LOW) ||
                       (phase_next == swhs_pkg::PH_START_HIGH);
    res.drive_level  = (phase_next == swhs_pkg::PH_START_HIGH);
    res.busy_res     = (phase_next != swhs_pkg::PH_IDLE);
  end

  // Advance the state on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= swhs_pkg::PH_IDLE;
      tick_count <= '0;
      bit_index  <= '0;
      shift_byte <= '0;
      byte_count <= '0;
    end else if (step) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
      byte_count <= byte_count_next;
    end
  end

endmodule

`default_nettype wire

[rtl/single_wire_humidity_sensor_reader.sv]
// Top level of the single-wire humidity sensor reader.
`default_nettype none
`include "single_wire_humidity_sensor_reader_macros.svh"

// Master side of the single-wire sensor exchange. Each input beat is either a
// one-microsecond tick carrying the sampled line level or a start request;
// every beat yields exactly one result beat. A beat is accepted in every cycle
// that the output register is empty or being drained, so the block sustains
// one item per clock; the result is computed combinationally from the state and
// the beat and is registered, so it appears in the cycle after acceptance.
// Drive the line from drive_enable / drive_level, and check the checksum in the
// caller. Configuration writes take effect at once.
module single_wire_humidity_sensor_reader (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Input beats
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [7:0]                        s_axis_tdata,  // [0] pin_level
  input  wire logic                              s_axis_tuser,  // [0] op
  // Result beats
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [0] drive_enable, [1] drive_level, [9:2] data_byte, [10] byte_valid,
  // [12:11] status, [13] status_valid, [14] busy_res, [15] zero
  output logic [swhs_pkg::DATA_WIDTH-1:0]        m_axis_tdata,
  output logic                                   m_axis_tlast,  // last_byte
  // Configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [swhs_pkg::IDX_WIDTH-1:0]    cfg_index,
  input  wire logic [swhs_pkg::REG_WIDTH-1:0]    cfg_data
);

  swhs_pkg::cfg_t cfg;
  swhs_pkg::res_t res;
  swhs_pkg::res_t res_out;
  logic           accept;
  logic           out_valid;

  swhs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Accept while the result slot is free or draining.
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  swhs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .op        (s_axis_tuser),
    .pin_level (s_axis_tdata[0]),
    .cfg       (cfg),
    .res       (res)
  );

  // Hold the result beat until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_out <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = res_out.last_byte;
  assign m_axis_tdata  = {1'b0, res_out.busy_res, res_out.status_valid, res_out.status,
                          res_out.byte_valid, res_out.data_byte, res_out.drive_level,
                          res_out.drive_enable};

  // A last byte always closes the transaction with status ok.
  `SWHS_ASSERT_IMP(a_last_ends, clk, rst, out_valid && res_out.last_byte,
    res_out.status_valid && res_out.byte_valid && !res_out.busy_res &&
    (res_out.status == swhs_pkg::ST_OK))
  // The line is driven high only while driving is enabled.
  `SWHS_ASSERT_IMP(a_drive, clk, rst, out_valid && res_out.drive_level,
    res_out.drive_enable && res_out.busy_res)
  // An end status leaves the block idle.
  `SWHS_ASSERT_IMP(a_end_idle, clk, rst, out_valid && res_out.status_valid,
    !res_out.busy_res && !res_out.drive_enable)
  // An accepted beat shows up as a result in the next cycle.
  `SWHS_ASSERT_NXT(a_beat_out, clk, rst, accept, out_valid)

endmodule

`default_nettype wire
